// ===== sv/gnt_pkg.sv =====
`timescale 1ns / 1ps
package gnt_pkg;

   typedef enum logic [2:0] {
      MODE_ADD    = 3'd0,
      MODE_DELETE = 3'd1,
      MODE_CLEAR  = 3'd2,
      MODE_GREEDY = 3'd3,
      MODE_PERIM  = 3'd4,
      MODE_MEMBER = 3'd5
   } mode_type;

   localparam int ATAN_STEPS = 32;

   // atan(2^-i) in 2^-32 turn units
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] r;
      begin
         unique case (i)
            5'd0: r = 32'd536870912;   5'd1: r = 32'd316933406;
            5'd2: r = 32'd167458907;   5'd3: r = 32'd85004756;
            5'd4: r = 32'd42667331;    5'd5: r = 32'd21354465;
            5'd6: r = 32'd10679838;    5'd7: r = 32'd5340245;
            5'd8: r = 32'd2670163;     5'd9: r = 32'd1335087;
            5'd10: r = 32'd667544;     5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;     5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;      5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;      5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;       5'd19: r = 32'd1304;
            5'd20: r = 32'd652;        5'd21: r = 32'd326;
            5'd22: r = 32'd163;        5'd23: r = 32'd81;
            5'd24: r = 32'd41;         5'd25: r = 32'd20;
            5'd26: r = 32'd10;         5'd27: r = 32'd5;
            5'd28: r = 32'd3;          5'd29: r = 32'd1;
            5'd30: r = 32'd1;          default: r = 32'd0;
         endcase
         return r;
      end
   endfunction

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // capture request word
      logic scan_first; // first entry of a scan
      logic scan_step;  // evaluate current entry
      logic sq_step;    // one square accumulate step
      logic cor_init;   // load cordic from vector
      logic cor_step;   // one micro-rotation
      logic ref_save;   // keep cordic result as reference direction
      logic write_add;  // commit add
      logic finish;     // drive result word
   } gnt_cmd_type;

   typedef struct packed {
      logic last_entry;
      logic cor_done;
   } gnt_sts_type;

endpackage

// ===== sv/geo_neighbor_table_next_hop.sv =====
`timescale 1ns / 1ps
// neighbor position table with greedy and perimeter next-hop selection.
// pulse start for one cycle when busy is low; the word is taken at that edge.
// exactly one result word follows on rsp_* for one cycle, marked by rsp_valid,
// in the first cycle with busy low again, and the receiver cannot stall it.
// add, delete, clear and membership hold busy through a decide, a simple and
// a done state. a greedy query computes own distance first, then per entry
// an index step, three square steps through one multiplier and a compare.
// a perimeter query relies on the single cordic unit doing ANGLE_BITS+2
// micro-rotations (at most ATAN_STEPS), one a cycle, for the reference
// direction and again for every entry.
// queries drop expired entries as they scan them.
module geo_neighbor_table_next_hop
   import gnt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int ANGLE_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_mode,
   input  logic [31:0]        req_neighbor_addr,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_self_x,
   input  logic signed [31:0] req_self_y,
   input  logic signed [31:0] req_self_z,
   input  logic [31:0]        req_now_time,
   input  logic               csr_write,
   input  logic [31:0]        csr_wdata,
   output logic               rsp_valid,
   output logic [31:0]        rsp_next_hop,
   output logic               rsp_hop_found,
   output logic               rsp_is_member,
   output logic               rsp_add_dropped
);

   gnt_cmd_type cmd;
   gnt_sts_type sts;

   // sequencer
   gnt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
      .clock, .reset, .start, .req_mode, .sts, .busy, .cmd
   );

   // table, distance and cordic datapath
   gnt_dp #(.TABLE_DEPTH(TABLE_DEPTH), .ANGLE_BITS(ANGLE_BITS)) u_dp (
      .clock, .reset, .cmd, .sts, .csr_write, .csr_wdata,
      .req_mode, .req_neighbor_addr, .req_pos_x, .req_pos_y, .req_pos_z,
      .req_self_x, .req_self_y, .req_self_z, .req_now_time,
      .rsp_valid, .rsp_next_hop, .rsp_hop_found, .rsp_is_member,
      .rsp_add_dropped
   );

endmodule

// ===== sv/gnt_ctrl.sv =====
`timescale 1ns / 1ps
module gnt_ctrl
   import gnt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  req_mode,
   input  gnt_sts_type sts,
   output logic        busy,
   output gnt_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECIDE, ST_SIMPLE, ST_REFINIT, ST_REFROT,
      ST_ENTRY, ST_SQ, ST_NINIT, ST_NROT, ST_EVAL, ST_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] mode_ff, mode_in;
   logic [1:0] sq_ff, sq_in;
   logic       first_ff, first_in;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      sq_in    = sq_ff;
      first_in = first_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               mode_in  = req_mode;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            first_in = 1'b1;
            sq_in    = 2'd0;
            if (mode_ff == MODE_PERIM) state_in = ST_REFINIT;
            else if (mode_ff == MODE_GREEDY) state_in = ST_SQ;
            else state_in = ST_SIMPLE;
         end
         ST_SIMPLE: begin
            cmd.write_add = (mode_ff == MODE_ADD);
            state_in = ST_DONE;
         end
         ST_REFINIT: begin
            cmd.cor_init = 1'b1;
            state_in = ST_REFROT;
         end
         ST_REFROT: begin
            cmd.cor_step = 1'b1;
            if (sts.cor_done) state_in = ST_ENTRY;
         end
         ST_ENTRY: begin
            sq_in = 2'd0;
            // last reference rotation has settled by now
            cmd.ref_save = first_ff && (mode_ff == MODE_PERIM);
            if (mode_ff == MODE_PERIM) state_in = ST_NINIT;
            else state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.sq_step = 1'b1;
            sq_in = sq_ff + 2'd1;
            if (sq_ff == 2'd2) state_in = ST_EVAL;
         end
         ST_NINIT: begin
            cmd.cor_init = 1'b1;
            state_in = ST_NROT;
         end
         ST_NROT: begin
            cmd.cor_step = 1'b1;
            if (sts.cor_done) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // first pass on greedy computes own distance only
            cmd.scan_first = first_ff;
            cmd.scan_step  = !(first_ff && mode_ff == MODE_GREEDY);
            if (first_ff && mode_ff == MODE_GREEDY) begin
               first_in = 1'b0;
               cmd.scan_first = 1'b1;
               state_in = ST_ENTRY;
            end else begin
               first_in = 1'b0;
               if (sts.last_entry) state_in = ST_DONE;
               else state_in = ST_ENTRY;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= '0;
         sq_ff    <= '0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         sq_ff    <= sq_in;
         first_ff <= first_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   a_idle_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy) else $error("load while busy");
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !busy) else $error("still busy after finish");
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> busy) else $error("not busy after load");

endmodule

// ===== sv/gnt_dp.sv =====
`timescale 1ns / 1ps
module gnt_dp
   import gnt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int ANGLE_BITS  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  gnt_cmd_type         cmd,
   output gnt_sts_type         sts,
   input  logic                csr_write,
   input  logic [31:0]         csr_wdata,
   input  logic [2:0]          req_mode,
   input  logic [31:0]         req_neighbor_addr,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic signed [31:0]  req_self_x,
   input  logic signed [31:0]  req_self_y,
   input  logic signed [31:0]  req_self_z,
   input  logic [31:0]         req_now_time,
   output logic                rsp_valid,
   output logic [31:0]         rsp_next_hop,
   output logic                rsp_hop_found,
   output logic                rsp_is_member,
   output logic                rsp_add_dropped
);

   localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int STEPS = (ANGLE_BITS + 2 > ATAN_STEPS) ? ATAN_STEPS : ANGLE_BITS + 2;
   localparam int CW    = 36; // cordic x/y width, growth by 1.65 over 33 bits

   logic [31:0] lifetime_ff;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [31:0]        t_addr [TABLE_DEPTH];
   logic signed [31:0] t_x [TABLE_DEPTH];
   logic signed [31:0] t_y [TABLE_DEPTH];
   logic signed [31:0] t_z [TABLE_DEPTH];
   logic [31:0]        t_stamp [TABLE_DEPTH];

   // captured request word
   logic [2:0]         mode_ff;
   logic [31:0]        addr_ff, now_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff, sx_ff, sy_ff, sz_ff;

   always_ff @(posedge clock) begin
      if (reset) lifetime_ff <= 32'd2000;
      else if (csr_write) lifetime_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         addr_ff <= req_neighbor_addr;
         now_ff  <= req_now_time;
         px_ff <= req_pos_x;  py_ff <= req_pos_y;  pz_ff <= req_pos_z;
         sx_ff <= req_self_x; sy_ff <= req_self_y; sz_ff <= req_self_z;
      end
   end

   // slot search over the TABLE_DEPTH registered addresses (independent compares)
   logic [TABLE_DEPTH-1:0] hit_vec;
   logic                   hit_any, free_any;
   logic [IW-1:0]          hit_idx, free_idx;
   always_comb begin
      hit_any = 1'b0; free_any = 1'b0; hit_idx = '0; free_idx = '0;
      for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
         hit_vec[k] = valid_ff[k] && (t_addr[k] == addr_ff);
         if (hit_vec[k]) begin hit_any = 1'b1; hit_idx = IW'(k); end
         if (!valid_ff[k]) begin free_any = 1'b1; free_idx = IW'(k); end
      end
   end

   // scan pointer and purge
   logic [IW-1:0] idx_ff;
   logic          cur_live;
   logic [32:0]   expiry;
   logic          scan_last, rot_done;
   assign expiry    = {1'b0, t_stamp[idx_ff]} + {1'b0, lifetime_ff};
   assign cur_live  = valid_ff[idx_ff] && (expiry > {1'b0, now_ff});
   assign scan_last = (idx_ff == IW'(TABLE_DEPTH - 1));

   // squared distance, one axis per step
   logic [1:0]         ax_ff;
   logic [65:0]        acc_ff;
   logic [65:0]        self_d_ff;
   logic               self_first_ff;
   logic signed [32:0] diff;
   logic [32:0]        mag;
   logic signed [31:0] ea, eb;
   always_comb begin
      unique case (ax_ff)
         2'd0: begin ea = t_x[idx_ff]; eb = px_ff; end
         2'd1: begin ea = t_y[idx_ff]; eb = py_ff; end
         default: begin ea = t_z[idx_ff]; eb = pz_ff; end
      endcase
      if (mode_ff == MODE_GREEDY && self_first_ff) begin
         unique case (ax_ff)
            2'd0: ea = sx_ff;
            2'd1: ea = sy_ff;
            default: ea = sz_ff;
         endcase
      end
      diff = 33'(ea) - 33'(eb);
      mag  = diff[32] ? 33'(-diff) : 33'(diff);
   end
   logic [65:0] sq_prod;
   assign sq_prod = 66'(mag) * 66'(mag);

   // cordic
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic [31:0]          cz_ff;
   logic [4:0]           cstep_ff;
   logic [ANGLE_BITS-1:0] ref_dir_ff, cur_dir;
   logic                  ref_ok_ff;
   logic                  idx_is_ref_ff; // high while reference direction is in flight
   logic signed [32:0]    vx, vy;
   always_comb begin
      if (cmd.ref_save || !ref_ok_ff || idx_is_ref_ff) begin
         vx = 33'(px_ff) - 33'(sx_ff);
         vy = 33'(py_ff) - 33'(sy_ff);
      end else begin
         vx = 33'(t_x[idx_ff]) - 33'(sx_ff);
         vy = 33'(t_y[idx_ff]) - 33'(sy_ff);
      end
   end
   logic [31:0] z_round;
   assign z_round = cz_ff + (32'd1 << (31 - ANGLE_BITS));
   assign cur_dir = z_round[31 -: ANGLE_BITS];
   assign rot_done = (cstep_ff == 5'(STEPS - 1));
   logic nzero_ff;

   assign sts = '{last_entry: scan_last, cor_done: rot_done};

   // best tracking
   logic              best_ok_ff, low_ok_ff;
   logic [65:0]       best_d_ff;
   logic [ANGLE_BITS-1:0] best_a_ff;
   logic [31:0]       best_addr_ff, low_addr_ff;
   logic [ANGLE_BITS-1:0] ang;
   assign ang = ref_dir_ff - cur_dir;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rsp_valid <= cmd.finish;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.write_add) begin
         if (hit_any) valid_in[hit_idx] = 1'b1;
         else if (free_any) valid_in[free_idx] = 1'b1;
      end
      if (mode_ff == MODE_DELETE && cmd.write_add == 1'b0 && cmd.finish && hit_any)
         valid_in[hit_idx] = 1'b0;
      if (mode_ff == MODE_CLEAR && cmd.finish) valid_in = '0;
      if (cmd.scan_step && !cur_live) valid_in[idx_ff] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.write_add && (hit_any || free_any)) begin
         t_addr[hit_any ? hit_idx : free_idx]  <= addr_ff;
         t_x[hit_any ? hit_idx : free_idx]     <= px_ff;
         t_y[hit_any ? hit_idx : free_idx]     <= py_ff;
         t_z[hit_any ? hit_idx : free_idx]     <= pz_ff;
         t_stamp[hit_any ? hit_idx : free_idx] <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff        <= '0;
         ax_ff         <= '0;
         acc_ff        <= '0;
         self_first_ff <= 1'b1;
         idx_is_ref_ff <= 1'b1;
         ref_ok_ff     <= 1'b1;
         best_ok_ff    <= 1'b0;
         low_ok_ff     <= 1'b0;
      end
      if (cmd.sq_step) begin
         acc_ff <= acc_ff + sq_prod;
         ax_ff  <= (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
      end
      if (cmd.cor_init) begin
         cstep_ff <= '0;
         nzero_ff <= (vx != 0) || (vy != 0);
         if (vx[32]) begin
            cx_ff <= CW'(-vx); cy_ff <= CW'(-vy); cz_ff <= 32'h8000_0000;
         end else begin
            cx_ff <= CW'(vx);  cy_ff <= CW'(vy);  cz_ff <= '0;
         end
      end
      if (cmd.cor_step && !rot_done) begin
         cstep_ff <= cstep_ff + 5'd1;
      end
      if (cmd.cor_step) begin
         if (!cy_ff[CW-1]) begin
            cx_ff <= cx_ff + (cy_ff >>> cstep_ff);
            cy_ff <= cy_ff - (cx_ff >>> cstep_ff);
            cz_ff <= cz_ff + atan_turn(cstep_ff);
         end else begin
            cx_ff <= cx_ff - (cy_ff >>> cstep_ff);
            cy_ff <= cy_ff + (cx_ff >>> cstep_ff);
            cz_ff <= cz_ff - atan_turn(cstep_ff);
         end
      end
      if (cmd.ref_save) begin
         idx_is_ref_ff <= 1'b0;
         ref_ok_ff     <= nzero_ff;
         ref_dir_ff    <= cur_dir;
      end
      if (cmd.scan_first && mode_ff == MODE_GREEDY && self_first_ff) begin
         self_d_ff     <= acc_ff;
         acc_ff        <= '0;
         self_first_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         acc_ff <= '0;
         if (!scan_last) idx_ff <= idx_ff + IW'(1);
         if (cur_live) begin
            if (!low_ok_ff || t_addr[idx_ff] < low_addr_ff) begin
               low_ok_ff   <= 1'b1;
               low_addr_ff <= t_addr[idx_ff];
            end
            if (mode_ff == MODE_GREEDY) begin
               if (!best_ok_ff || acc_ff < best_d_ff ||
                   (acc_ff == best_d_ff && t_addr[idx_ff] < best_addr_ff)) begin
                  best_ok_ff   <= 1'b1;
                  best_d_ff    <= acc_ff;
                  best_addr_ff <= t_addr[idx_ff];
               end
            end else if (ref_ok_ff && nzero_ff && ang != '0) begin
               if (!best_ok_ff || ang < best_a_ff ||
                   (ang == best_a_ff && t_addr[idx_ff] < best_addr_ff)) begin
                  best_ok_ff   <= 1'b1;
                  best_a_ff    <= ang;
                  best_addr_ff <= t_addr[idx_ff];
               end
            end
         end
      end
   end

   // result word
   logic [31:0] rsp_next_hop_in;
   logic        rsp_hop_found_in, rsp_is_member_in, rsp_add_dropped_in;
   always_comb begin
      rsp_next_hop_in    = '0;
      rsp_hop_found_in   = 1'b0;
      rsp_is_member_in   = (mode_ff == MODE_MEMBER) && hit_any;
      rsp_add_dropped_in = 1'b0;
      unique case (mode_ff)
         MODE_ADD: rsp_add_dropped_in = !hit_any && !free_any;
         MODE_GREEDY: begin
            if (best_ok_ff && best_d_ff < self_d_ff) begin
               rsp_next_hop_in  = best_addr_ff;
               rsp_hop_found_in = 1'b1;
            end
         end
         MODE_PERIM: begin
            if (best_ok_ff) begin
               rsp_next_hop_in  = best_addr_ff;
               rsp_hop_found_in = 1'b1;
            end else if (low_ok_ff) begin
               rsp_next_hop_in  = low_addr_ff;
               rsp_hop_found_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_next_hop    <= rsp_next_hop_in;
         rsp_hop_found   <= rsp_hop_found_in;
         rsp_is_member   <= rsp_is_member_in;
         rsp_add_dropped <= rsp_add_dropped_in;
      end
   end

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hop_found && rsp_add_dropped)) else $error("flag clash");
   a_member_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_member |-> !rsp_hop_found) else $error("member with hop");
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_add_dropped |-> (&valid_ff)) else $error("drop with room");

endmodule
